FILE: rtl/pthc_pkg.sv
// Package for the pitch to hue color unit.
// Holds the fixed-point formats, the log2 segment table and the hue sector codes.
// It depends on nothing else.
`default_nettype none
package pthc_pkg;

  localparam int PITCH_W = 24;
  localparam int COLOR_W = 24;
  localparam int CHAN_W = 8;
  localparam int PITCH_FRAC_BITS = 8;
  localparam int LOG_FRAC_BITS = 16;

  localparam int LEAD_W = 5;
  localparam int SEG_BITS = 4;
  localparam int REM_BITS = 19;
  localparam int TAB_FRAC = 16;
  localparam int TAB_W = 17;
  localparam int DIFF_W = 13;
  localparam int PROD_W = DIFF_W + REM_BITS;

  localparam int LSH = (LOG_FRAC_BITS >= TAB_FRAC) ? LOG_FRAC_BITS - TAB_FRAC : 0;
  localparam int RSH = (LOG_FRAC_BITS >= TAB_FRAC) ? 0 : TAB_FRAC - LOG_FRAC_BITS;
  localparam int VSH_W = TAB_W + LSH;
  localparam int HUE_W = LOG_FRAC_BITS + 3;
  localparam int SECTOR_W = 3;

  localparam int VAL2_X255 = 459;
  localparam int RISE_PROD_W = LOG_FRAC_BITS + 9;
  localparam int FALL_PROD_W = LOG_FRAC_BITS + 10;
  localparam logic [CHAN_W-1:0] FULL_LEVEL = 8'd229;

  localparam logic [PITCH_W-1:0] ONE_HZ = PITCH_W'(1) << PITCH_FRAC_BITS;

  localparam logic [SECTOR_W-1:0] SEC_RED_GREEN_UP = 3'd0;
  localparam logic [SECTOR_W-1:0] SEC_GREEN_RED_DN = 3'd1;
  localparam logic [SECTOR_W-1:0] SEC_GREEN_BLUE_UP = 3'd2;
  localparam logic [SECTOR_W-1:0] SEC_BLUE_GREEN_DN = 3'd3;
  localparam logic [SECTOR_W-1:0] SEC_BLUE_RED_UP = 3'd4;

  // log2(1 + k/16) in unsigned Q1.16, with the end point 1.0 at k = 16.
  function automatic logic [TAB_W-1:0] log_seg(input logic [SEG_BITS:0] k);
    logic [TAB_W-1:0] t;
    case (k)
      5'd0: t = 17'd0;
      5'd1: t = 17'd5732;
      5'd2: t = 17'd11136;
      5'd3: t = 17'd16248;
      5'd4: t = 17'd21098;
      5'd5: t = 17'd25711;
      5'd6: t = 17'd30109;
      5'd7: t = 17'd34312;
      5'd8: t = 17'd38336;
      5'd9: t = 17'd42196;
      5'd10: t = 17'd45904;
      5'd11: t = 17'd49472;
      5'd12: t = 17'd52911;
      5'd13: t = 17'd56229;
      5'd14: t = 17'd59434;
      5'd15: t = 17'd62534;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/pitch_to_hue_color_unit.sv
// Top level of the pitch to hue color unit: a six-stage pipeline from pitch to RGB color.
// It depends on pthc_pkg for formats, the log2 table and the sector codes.
// One pitch is taken every cycle unless the pipeline is stalled back to the input.
// The rate is set by the pipeline stages; each stage holds while the one after it is full
// and stalled, and empty stages are filled even while the output waits.
// Reset is synchronous and clears every stage valid bit; payload registers are not reset.
`default_nettype none
module pitch_to_hue_color_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [pthc_pkg::PITCH_W-1:0] s_axis_tdata,  // [23:0] pitch_hz
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [pthc_pkg::COLOR_W-1:0]     m_axis_tdata,  // [23:0] packed_color
  output logic [0:0]                       m_axis_tuser   // [0] pitch_valid
);
  import pthc_pkg::*;

  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  logic [PITCH_W-1:0] p1;
  logic [LEAD_W-1:0] lead1;
  logic ok1;
  logic [SEG_BITS-1:0] idx2;
  logic [REM_BITS-1:0] rem2;
  logic ok2;
  logic [TAB_FRAC-1:0] t0_3;
  logic [PROD_W-1:0] prod3;
  logic ok3;
  logic [HUE_W-1:0] h4;
  logic ok4;
  logic [SECTOR_W-1:0] sector5;
  logic [CHAN_W-1:0] rise5, fall5;
  logic ok5;

  logic [LEAD_W-1:0] lead_next;
  logic [PITCH_W-1:0] norm;
  logic [TAB_W-1:0] t0, t1;
  logic [DIFF_W-1:0] diff;
  logic [TAB_W-1:0] v16;
  logic [LOG_FRAC_BITS-1:0] vl;
  logic [LOG_FRAC_BITS-1:0] frac;
  logic [LOG_FRAC_BITS:0] one_minus;
  logic [RISE_PROD_W-1:0] rise_prod;
  logic [FALL_PROD_W-1:0] fall_prod;
  logic [CHAN_W-1:0] r, g, b;

  assign en6 = !v6 || m_axis_tready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v6;

  always_comb begin
    lead_next = '0;
    for (int i = 0; i < PITCH_W; i++) begin
      if (s_axis_tdata[i]) begin
        lead_next = LEAD_W'(i);
      end
    end
  end

  always_comb begin
    norm = p1 << (LEAD_W'(PITCH_W - 1) - lead1);
    t0 = log_seg({1'b0, idx2});
    t1 = log_seg({1'b0, idx2} + (SEG_BITS + 1)'(1));
    diff = DIFF_W'(t1 - t0);
    v16 = {1'b0, t0_3} + TAB_W'(prod3[PROD_W-1:REM_BITS]);
    vl = LOG_FRAC_BITS'((VSH_W'(v16) << LSH) >> RSH);
    frac = h4[LOG_FRAC_BITS-1:0];
    one_minus = ((LOG_FRAC_BITS + 1)'(1) << LOG_FRAC_BITS) - {1'b0, frac};
    rise_prod = RISE_PROD_W'(VAL2_X255) * RISE_PROD_W'(frac);
    fall_prod = FALL_PROD_W'(VAL2_X255) * FALL_PROD_W'(one_minus);
  end

  always_comb begin
    unique case (sector5)
      SEC_RED_GREEN_UP: begin
        r = FULL_LEVEL; g = rise5; b = '0;
      end
      SEC_GREEN_RED_DN: begin
        r = fall5; g = FULL_LEVEL; b = '0;
      end
      SEC_GREEN_BLUE_UP: begin
        r = '0; g = FULL_LEVEL; b = rise5;
      end
      SEC_BLUE_GREEN_DN: begin
        r = '0; g = fall5; b = FULL_LEVEL;
      end
      SEC_BLUE_RED_UP: begin
        r = rise5; g = '0; b = FULL_LEVEL;
      end
      default: begin
        r = FULL_LEVEL; g = '0; b = fall5;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1 <= s_axis_tdata;
      lead1 <= lead_next;
      ok1 <= s_axis_tdata >= ONE_HZ;
    end
    if (en2) begin
      idx2 <= norm[PITCH_W-2 -: SEG_BITS];
      rem2 <= norm[REM_BITS-1:0];
      ok2 <= ok1;
    end
    if (en3) begin
      t0_3 <= t0[TAB_FRAC-1:0];
      prod3 <= PROD_W'(diff) * PROD_W'(rem2);
      ok3 <= ok2;
    end
    if (en4) begin
      h4 <= HUE_W'(vl) * HUE_W'(6);
      ok4 <= ok3;
    end
    if (en5) begin
      sector5 <= h4[HUE_W-1:LOG_FRAC_BITS];
      rise5 <= CHAN_W'(rise_prod >> (LOG_FRAC_BITS + 1));
      fall5 <= CHAN_W'(fall_prod >> (LOG_FRAC_BITS + 1));
      ok5 <= ok4;
    end
    if (en6) begin
      m_axis_tdata <= ok5 ? {r, g, b} : '0;
      m_axis_tuser <= ok5;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/pthc_checker.sv
// Port-level checker for the pitch to hue color unit, bound to its top level.
// It sees only the top level ports and needs no package.
`default_nettype none
module pthc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output valid after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Stalled output transfer changed.");

  a_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 24'd0)
    else $error("Pitch below one hertz did not give black.");

  a_levels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:16] <= 8'd229 && m_axis_tdata[15:8] <= 8'd229
      && m_axis_tdata[7:0] <= 8'd229)
    else $error("Channel above value level.");

  a_one_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:16] == 8'd0 || m_axis_tdata[15:8] == 8'd0
      || m_axis_tdata[7:0] == 8'd0)
    else $error("Fully saturated color has no zero channel.");

endmodule

bind pitch_to_hue_color_unit pthc_checker u_pthc_checker (.*);
`default_nettype wire
